// ----- sv/ps2_keyboard_link_and_modifiers_unit_assert.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the ps/2 keyboard link
// ---------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_LINK_AND_MODIFIERS_UNIT_ASSERT_SVH
`define PS2_KEYBOARD_LINK_AND_MODIFIERS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PS2KB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2kb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PS2KB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2kb assertion failed");

`endif

// ----- sv/ps2kb_pkg.sv -----
// ---------------------------------------------------------------------------
// ps2kb_pkg
// shared byte codes, flag bundle and parity helper for the ps/2 link
// ---------------------------------------------------------------------------
package ps2kb_pkg;

  // protocol bytes
  localparam logic [7:0] BYTE_RELEASE = 8'hF0;
  localparam logic [7:0] BYTE_ACK     = 8'hFA;
  localparam logic [7:0] BYTE_EXT0    = 8'hE0;
  localparam logic [7:0] BYTE_EXT1    = 8'hE1;

  // scancodes with special handling
  localparam logic [7:0] KEY_LSHIFT   = 8'h12;
  localparam logic [7:0] KEY_RSHIFT   = 8'h59;
  localparam logic [7:0] KEY_ALT      = 8'h11;
  localparam logic [7:0] KEY_CTRL     = 8'h14;
  localparam logic [7:0] KEY_CAPS     = 8'h58;
  localparam logic [7:0] KEY_NUM      = 8'h77;
  localparam logic [7:0] KEY_SCROLL   = 8'h7E;

  // frame bit positions (count after the step)
  localparam logic [3:0] RX_CNT_PARITY = 4'd10;
  localparam logic [3:0] RX_CNT_STOP   = 4'd11;
  localparam logic [3:0] TX_CNT_START  = 4'd1;
  localparam logic [3:0] TX_CNT_D_LO   = 4'd2;
  localparam logic [3:0] TX_CNT_D_HI   = 4'd9;
  localparam logic [3:0] TX_CNT_PARITY = 4'd10;
  localparam logic [3:0] TX_CNT_STOP   = 4'd11;

  // keyboard prefix, modifier and lock flags
  typedef struct packed {
    logic scroll_on;
    logic num_on;
    logic caps_on;
    logic shift_held;
    logic alt_held;
    logic ctrl_held;
    logic extend_pending;
    logic release_pending;
  } kb_flags_t;

  // result of decoding one received byte
  typedef struct packed {
    kb_flags_t  flags;
    logic       key_valid;
    logic [7:0] key_code;
    logic       ack_seen;
  } kb_decode_t;

  // bit that makes the byte plus itself hold an odd number of ones
  function automatic logic odd_bit(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

// ----- sv/ps2kb_byte_decode.sv -----
// ---------------------------------------------------------------------------
// ps2kb_byte_decode
// classifies a received byte and updates prefix, modifier and lock flags
// ---------------------------------------------------------------------------
module ps2kb_byte_decode (
  input  logic [7:0]             rx_byte,
  input  ps2kb_pkg::kb_flags_t   flags_cur,
  output ps2kb_pkg::kb_decode_t  dec
);
  import ps2kb_pkg::*;

  // byte classification
  always_comb begin
    dec           = '0;
    dec.flags     = flags_cur;
    if (rx_byte == BYTE_RELEASE) begin
      dec.flags.release_pending = 1'b1;
      dec.flags.extend_pending  = 1'b0;
    end else if (rx_byte == BYTE_ACK) begin
      dec.ack_seen = 1'b1;
    end else if (rx_byte == BYTE_EXT0 || rx_byte == BYTE_EXT1) begin
      dec.flags.extend_pending = 1'b1;
    end else if (rx_byte == KEY_LSHIFT || rx_byte == KEY_RSHIFT) begin
      dec.flags.shift_held      = ~flags_cur.release_pending;
      dec.flags.release_pending = 1'b0;
    end else if (rx_byte == KEY_ALT) begin
      dec.flags.alt_held        = ~flags_cur.release_pending;
      dec.flags.release_pending = 1'b0;
    end else if (rx_byte == KEY_CTRL) begin
      dec.flags.ctrl_held       = ~flags_cur.release_pending;
      dec.flags.release_pending = 1'b0;
    end else if (rx_byte == KEY_CAPS || rx_byte == KEY_NUM || rx_byte == KEY_SCROLL) begin
      // lock keys toggle on press, release just clears the prefix
      if (flags_cur.release_pending) begin
        dec.flags.release_pending = 1'b0;
      end else begin
        if (rx_byte == KEY_CAPS) begin
          dec.flags.caps_on = ~flags_cur.caps_on;
        end else if (rx_byte == KEY_NUM) begin
          dec.flags.num_on = ~flags_cur.num_on;
        end else begin
          dec.flags.scroll_on = ~flags_cur.scroll_on;
        end
        dec.key_valid = 1'b1;
        dec.key_code  = rx_byte;
      end
    end else if (flags_cur.release_pending) begin
      dec.flags.release_pending = 1'b0;
    end else if (rx_byte != 8'h00) begin
      dec.key_valid = 1'b1;
      dec.key_code  = rx_byte;
    end
  end

endmodule

// ----- sv/ps2_keyboard_link_and_modifiers_unit.sv -----
// ---------------------------------------------------------------------------
// ps2_keyboard_link_and_modifiers_unit
// ps/2 host link with frame receive, command transmit and modifier tracking
// ---------------------------------------------------------------------------
// Usage:
//   in_* channel: one transaction per falling keyboard clock edge
//   (in_func = 0, in_data_bit = sampled data line) or per command request
//   (in_func = 1, in_cmd_byte = byte to send).
//   out_* channel: exactly one result transaction per input transaction,
//   carrying the data line drive level, any accepted scancode, modifier and
//   lock status, the extend flag and ack, transmit-done and parity flags.
// Latency: a result is valid the cycle after its input is accepted.
// Throughput: one transaction per cycle; the link state update and byte
//   decode sit in one combinational pass ahead of the result register.
// Stall: while a result waits and out_ready is low, the result register
//   holds and in_ready drops, so no input is taken until that result is
//   taken; an empty result register still takes an input.
// Reset (rst_n low, synchronous): all link, modifier and lock state
//   cleared, internal data line drive released, result register empty.
// ---------------------------------------------------------------------------
module ps2_keyboard_link_and_modifiers_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic       in_data_bit,
  input  logic [7:0] in_cmd_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_data_drive_low,
  output logic       out_key_valid,
  output logic [7:0] out_key_code,
  output logic [5:0] out_modifier_status,
  output logic       out_extended,
  output logic       out_ack_byte_seen,
  output logic       out_tx_done,
  output logic       out_tx_acked,
  output logic       out_parity_error
);
  import ps2kb_pkg::*;

  // link state
  logic [3:0] rx_bit_count_r, rx_bit_count_nxt;
  logic [7:0] rx_shift_r, rx_shift_nxt;
  logic       rx_bad_r, rx_bad_nxt;
  kb_flags_t  flags_r, flags_nxt;
  logic       tx_busy_r, tx_busy_nxt;
  logic [3:0] tx_bit_count_r, tx_bit_count_nxt;
  logic [7:0] tx_shift_r, tx_shift_nxt;
  logic       tx_parity_r, tx_parity_nxt;
  logic       drive_low_r, drive_low_nxt;

  // result register
  logic       out_valid_r;
  logic       out_key_valid_r, out_key_valid_nxt;
  logic [7:0] out_key_code_r, out_key_code_nxt;
  logic       out_ack_byte_seen_r, out_ack_byte_seen_nxt;
  logic       out_tx_done_r, out_tx_done_nxt;
  logic       out_tx_acked_r, out_tx_acked_nxt;
  logic       out_parity_error_r, out_parity_error_nxt;
  logic       out_drive_low_r;
  kb_flags_t  out_flags_r;

  logic       in_fire;
  logic [7:0] rx_shift_in;
  logic [3:0] rx_cnt_inc;
  logic [3:0] tx_cnt_inc;
  kb_decode_t dec;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign rx_cnt_inc  = rx_bit_count_r + 4'd1;
  assign tx_cnt_inc  = tx_bit_count_r + 4'd1;
  assign rx_shift_in = (rx_bit_count_r >= 4'd1 && rx_bit_count_r <= 4'd8) ?
                       {in_data_bit, rx_shift_r[7:1]} : rx_shift_r;

  // byte decode on the completed frame
  ps2kb_byte_decode u_decode (
    .rx_byte   (rx_shift_in),
    .flags_cur (flags_r),
    .dec       (dec)
  );

  // next state and result for one transaction
  always_comb begin
    rx_bit_count_nxt      = rx_bit_count_r;
    rx_shift_nxt          = rx_shift_r;
    rx_bad_nxt            = rx_bad_r;
    flags_nxt             = flags_r;
    tx_busy_nxt           = tx_busy_r;
    tx_bit_count_nxt      = tx_bit_count_r;
    tx_shift_nxt          = tx_shift_r;
    tx_parity_nxt         = tx_parity_r;
    drive_low_nxt         = drive_low_r;
    out_key_valid_nxt     = 1'b0;
    out_key_code_nxt      = 8'h00;
    out_ack_byte_seen_nxt = 1'b0;
    out_tx_done_nxt       = 1'b0;
    out_tx_acked_nxt      = 1'b0;
    out_parity_error_nxt  = 1'b0;
    if (in_func) begin
      // command request: start bit driven at once
      tx_busy_nxt      = 1'b1;
      tx_bit_count_nxt = 4'd0;
      tx_shift_nxt     = in_cmd_byte;
      tx_parity_nxt    = odd_bit(in_cmd_byte);
      drive_low_nxt    = 1'b1;
    end else if (tx_busy_r) begin
      // transmit frame, receive paused
      tx_bit_count_nxt = tx_cnt_inc;
      if (tx_cnt_inc == TX_CNT_START) begin
        drive_low_nxt = 1'b1;
      end else if (tx_cnt_inc >= TX_CNT_D_LO && tx_cnt_inc <= TX_CNT_D_HI) begin
        drive_low_nxt = ~tx_shift_r[0];
        tx_shift_nxt  = {1'b0, tx_shift_r[7:1]};
      end else if (tx_cnt_inc == TX_CNT_PARITY) begin
        drive_low_nxt = ~tx_parity_r;
      end else if (tx_cnt_inc == TX_CNT_STOP) begin
        drive_low_nxt = 1'b0;
      end else begin
        drive_low_nxt    = 1'b0;
        tx_busy_nxt      = 1'b0;
        out_tx_done_nxt  = 1'b1;
        out_tx_acked_nxt = ~in_data_bit;
      end
    end else begin
      // receive frame
      rx_shift_nxt     = rx_shift_in;
      rx_bit_count_nxt = rx_cnt_inc;
      if (rx_cnt_inc == RX_CNT_PARITY) begin
        rx_bad_nxt = (in_data_bit != odd_bit(rx_shift_in));
      end
      if (rx_cnt_inc >= RX_CNT_STOP) begin
        if (rx_bad_r) begin
          out_parity_error_nxt = 1'b1;
        end else begin
          flags_nxt             = dec.flags;
          out_key_valid_nxt     = dec.key_valid;
          out_key_code_nxt      = dec.key_code;
          out_ack_byte_seen_nxt = dec.ack_seen;
        end
        rx_shift_nxt     = 8'h00;
        rx_bit_count_nxt = 4'd0;
        rx_bad_nxt       = 1'b0;
      end
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_bit_count_r <= 4'd0;
      rx_shift_r     <= 8'h00;
      rx_bad_r       <= 1'b0;
      flags_r        <= '0;
      tx_busy_r      <= 1'b0;
      tx_bit_count_r <= 4'd0;
      tx_shift_r     <= 8'h00;
      tx_parity_r    <= 1'b0;
      drive_low_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        rx_bit_count_r <= rx_bit_count_nxt;
        rx_shift_r     <= rx_shift_nxt;
        rx_bad_r       <= rx_bad_nxt;
        flags_r        <= flags_nxt;
        tx_busy_r      <= tx_busy_nxt;
        tx_bit_count_r <= tx_bit_count_nxt;
        tx_shift_r     <= tx_shift_nxt;
        tx_parity_r    <= tx_parity_nxt;
        drive_low_r    <= drive_low_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_drive_low_r     <= drive_low_nxt;
      out_flags_r         <= flags_nxt;
      out_key_valid_r     <= out_key_valid_nxt;
      out_key_code_r      <= out_key_code_nxt;
      out_ack_byte_seen_r <= out_ack_byte_seen_nxt;
      out_tx_done_r       <= out_tx_done_nxt;
      out_tx_acked_r      <= out_tx_acked_nxt;
      out_parity_error_r  <= out_parity_error_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data_drive_low  = out_drive_low_r;
  assign out_key_valid       = out_key_valid_r;
  assign out_key_code        = out_key_code_r;
  assign out_modifier_status = {out_flags_r.scroll_on, out_flags_r.num_on,
                                out_flags_r.caps_on, out_flags_r.shift_held,
                                out_flags_r.alt_held, out_flags_r.ctrl_held};
  assign out_extended        = out_flags_r.extend_pending;
  assign out_ack_byte_seen   = out_ack_byte_seen_r;
  assign out_tx_done         = out_tx_done_r;
  assign out_tx_acked        = out_tx_acked_r;
  assign out_parity_error    = out_parity_error_r;

  // checks
  `include "ps2_keyboard_link_and_modifiers_unit_assert.svh"

  `PS2KB_ASSERT_IMPL(a_acked_needs_done, out_valid_r && out_tx_acked_r, out_tx_done_r)
  `PS2KB_ASSERT_IMPL(a_bad_frame_no_key, out_valid_r && out_parity_error_r,
                     !out_key_valid_r && !out_ack_byte_seen_r)
  `PS2KB_ASSERT_NEXT(a_rx_hold_during_tx, in_fire && !in_func && tx_busy_r,
                     $stable(rx_bit_count_r) && $stable(rx_shift_r))
  `PS2KB_ASSERT_IMPL(a_rx_count_range, 1'b1, rx_bit_count_r <= RX_CNT_PARITY)

endmodule
